@@ rtl/core/srctok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctok_pkg
// Shared types, character codes and token kinds for the source tokenizer.
// ----------------------------------------------------------------------------
package srctok_pkg;

    // token kinds as seen on the result port
    typedef enum logic [4:0] {
        KIND_NONE   = 5'd0,
        KIND_NUMBER = 5'd1,
        KIND_IDENT  = 5'd2,
        KIND_LET    = 5'd3,
        KIND_CONST  = 5'd4,
        KIND_FN     = 5'd5,
        KIND_RETURN = 5'd6,
        KIND_PLUS   = 5'd7,
        KIND_MINUS  = 5'd8,
        KIND_STAR   = 5'd9,
        KIND_SLASH  = 5'd10,
        KIND_LPAREN = 5'd11,
        KIND_RPAREN = 5'd12,
        KIND_LBRACE = 5'd13,
        KIND_RBRACE = 5'd14,
        KIND_COLON  = 5'd15,
        KIND_EQUAL  = 5'd16,
        KIND_EQEQ   = 5'd17,
        KIND_DOT    = 5'd18
    } token_kind_t;

    // one result word
    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        last;
    } token_t;

    // tokens produced by one byte, handed to the result queue
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // identifier prefix kept for keyword matching
    localparam int PREFIX_W = 48;
    localparam logic [PREFIX_W-1:0] KW_LET    = 48'h0000_006C_6574;
    localparam logic [PREFIX_W-1:0] KW_CONST  = 48'h0063_6F6E_7374;
    localparam logic [PREFIX_W-1:0] KW_FN     = 48'h0000_0000_666E;
    localparam logic [PREFIX_W-1:0] KW_RETURN = 48'h7265_7475_726E;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    // kind of a single-character operator other than minus and equal, none for anything else
    function automatic token_kind_t op_kind(input logic [7:0] b);
        token_kind_t k;
        case (b)
            CH_PLUS:   k = KIND_PLUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COLON:  k = KIND_COLON;
            CH_DOT:    k = KIND_DOT;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/core/srctok_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctok_lexer
// Input word register and scanner state; works out up to two tokens per
// byte and pushes them to the result queue together once the queue has room.
// ----------------------------------------------------------------------------
module srctok_lexer #(
    parameter int POSITION_BITS    = 16,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         code_byte,
    input  logic               end_of_code,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               room,
    output srctok_pkg::push_t  push
);
    import srctok_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_NUM   = 5'b00010,
        MODE_IDENT = 5'b00100,
        MODE_MINUS = 5'b01000,
        MODE_EQUAL = 5'b10000
    } scan_mode_t;

    // input word register
    logic                     inv_reg;
    logic [7:0]               byte_reg;
    logic                     end_reg;
    logic                     fire;

    // scanner state
    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [PREFIX_W-1:0]      prefix_reg, prefix_next;

    // candidate tokens in emission order
    logic                     a_valid, b_valid, c_valid, fresh;
    token_t                   tok_a, tok_b, tok_c;
    token_kind_t              op_k;
    logic                     b_dig, b_let, b_spc;
    logic [1:0]               count;

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
        return (len >= LEN_MAX) ? LEN_MAX : len + LEN_W'(1);
    endfunction

    function automatic token_t make_tok(input token_kind_t k,
                                        input logic [POSITION_BITS-1:0] p,
                                        input logic [LEN_W-1:0] len);
        token_t t;
        t.kind   = k;
        t.start  = 16'(p);
        t.length = 8'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    // keywords need the exact length as well as the prefix
    function automatic token_kind_t word_kind(input logic [LEN_W-1:0] len,
                                              input logic [PREFIX_W-1:0] pre);
        token_kind_t k;
        if (len == LEN_W'(3) && pre == KW_LET)
            k = KIND_LET;
        else if (len == LEN_W'(5) && pre == KW_CONST)
            k = KIND_CONST;
        else if (len == LEN_W'(2) && pre == KW_FN)
            k = KIND_FN;
        else if (len == LEN_W'(6) && pre == KW_RETURN)
            k = KIND_RETURN;
        else
            k = KIND_IDENT;
        return k;
    endfunction

    // token left behind by a pending mode
    function automatic token_t flush_tok(input scan_mode_t m,
                                         input logic [POSITION_BITS-1:0] p,
                                         input logic [LEN_W-1:0] len,
                                         input logic [PREFIX_W-1:0] pre);
        token_t t;
        unique case (m)
            MODE_NUM:   t = make_tok(KIND_NUMBER, p, len);
            MODE_IDENT: t = make_tok(word_kind(len, pre), p, len);
            MODE_MINUS: t = make_tok(KIND_MINUS, p, LEN_W'(1));
            MODE_EQUAL: t = make_tok(KIND_EQUAL, p, LEN_W'(1));
            default:    t = make_tok(KIND_NONE, p, LEN_W'(0));
        endcase
        return t;
    endfunction

    // handshake: the held word moves on when the queue has room for two
    assign fire     = inv_reg && room;
    assign in_ready = !inv_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            inv_reg <= 1'b1;
        end
        else if (fire)
        begin
            inv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= code_byte;
            end_reg  <= end_of_code;
        end
    end

    // byte classes
    assign b_dig = is_digit(byte_reg);
    assign b_let = is_letter(byte_reg);
    assign b_spc = is_space(byte_reg);
    assign op_k  = op_kind(byte_reg);

    // scanner step for the held byte
    always_comb
    begin
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        c_valid     = 1'b0;
        fresh       = 1'b0;
        tok_a       = '0;
        tok_b       = '0;
        tok_c       = '0;

        // continue or close the pending token
        unique case (mode_reg)
            MODE_NUM:
            begin
                if (b_dig)
                    len_next = grow(len_reg);
                else
                begin
                    a_valid = 1'b1;
                    tok_a   = flush_tok(mode_reg, begin_reg, len_reg, prefix_reg);
                    fresh   = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (b_dig || b_let)
                begin
                    if (len_reg < LEN_W'(6))
                        prefix_next = {prefix_reg[PREFIX_W-9:0], byte_reg};
                    len_next = grow(len_reg);
                end
                else
                begin
                    a_valid = 1'b1;
                    tok_a   = flush_tok(mode_reg, begin_reg, len_reg, prefix_reg);
                    fresh   = 1'b1;
                end
            end
            MODE_MINUS:
            begin
                if (b_dig)
                begin
                    mode_next = MODE_NUM;
                    len_next  = grow(LEN_W'(1));
                end
                else
                begin
                    a_valid = 1'b1;
                    tok_a   = flush_tok(mode_reg, begin_reg, len_reg, prefix_reg);
                    fresh   = 1'b1;
                end
            end
            MODE_EQUAL:
            begin
                a_valid = 1'b1;
                if (byte_reg == CH_EQUAL)
                begin
                    tok_a     = make_tok(KIND_EQEQ, begin_reg, LEN_W'(2));
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    tok_a = flush_tok(mode_reg, begin_reg, len_reg, prefix_reg);
                    fresh = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // start a new token at this byte
        if (fresh)
        begin
            mode_next = MODE_IDLE;
            if (!b_spc)
            begin
                begin_next  = pos_reg;
                len_next    = LEN_W'(1);
                prefix_next = '0;
                if (b_dig)
                    mode_next = MODE_NUM;
                else if (b_let)
                begin
                    mode_next   = MODE_IDENT;
                    prefix_next = PREFIX_W'(byte_reg);
                end
                else if (byte_reg == CH_MINUS)
                    mode_next = MODE_MINUS;
                else if (byte_reg == CH_EQUAL)
                    mode_next = MODE_EQUAL;
                else
                begin
                    b_valid = 1'b1;
                    tok_b   = make_tok(op_k, pos_reg,
                                       (op_k == KIND_NONE) ? LEN_W'(0) : LEN_W'(1));
                end
            end
        end

        // end of source closes whatever is pending and rewinds the position
        if (end_reg)
        begin
            c_valid   = (mode_next != MODE_IDLE);
            tok_c     = flush_tok(mode_next, begin_next, len_next, prefix_next);
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    // pack the tokens in order; a single-character token and an end flush
    // never both occur for one byte
    assign count = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid};

    always_comb
    begin
        push.valid     = fire;
        push.count     = count;
        push.tok0      = a_valid ? tok_a : (b_valid ? tok_b : tok_c);
        push.tok1      = b_valid ? tok_b : tok_c;
        push.tok0.last = (count == 2'd1);
        push.tok1.last = 1'b1;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

@@ rtl/core/srctok_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctok_queue
// Four-word result queue taking up to two tokens per cycle and giving one
// token per cycle on the output handshake.
// ----------------------------------------------------------------------------
module srctok_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  srctok_pkg::push_t  push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output srctok_pkg::token_t head
);
    import srctok_pkg::*;

    token_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]          n_push;
    logic                pop;

    assign n_push    = push.valid ? push.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign head      = entry_reg[rd_reg];

    // room for a full pair, judged without the pop of this cycle
    assign room = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // pointer and fill update
    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(n_push);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_reg] <= push.tok0;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_reg + QPTR_W'(1)] <= push.tok1;
        end
    end

endmodule

@@ rtl/core/source_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle and sustains that rate while each byte
// yields at most one token and the output is drained every cycle; a byte
// that closes one token and emits another (or flushes at end of source)
// gives two words, which leave one at a time through a four-word result
// queue, so output drain at one word per cycle sets the limit there. A byte
// sits in the input register until the queue has room for two words and
// then moves its tokens into the queue, whose head drives the output.
// Lengths saturate at MAX_TOKEN_LENGTH and positions wrap at POSITION_BITS.
// ----------------------------------------------------------------------------
module source_tokenizer #(
    parameter int POSITION_BITS    = 16,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        end_of_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [7:0]  token_length,
    output logic        last_of_run
);
    import srctok_pkg::*;

    push_t  push;
    logic   room;
    token_t head;

    // scanner
    srctok_lexer #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_byte   (code_byte),
        .end_of_code (end_of_code),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .room        (room),
        .push        (push)
    );

    // result queue
    srctok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // result word fields
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule

@@ tb/tokenizer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tokenizer_checker
// Watches both channels of the source tokenizer, predicts the tokens that
// each accepted byte produces and compares every output word against them.
// ----------------------------------------------------------------------------
module tokenizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        end_of_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  token_kind,
    input  logic [15:0] token_start,
    input  logic [7:0]  token_length,
    input  logic        last_of_run,
    output int          mismatches,
    output int          tokens_due,
    output int          tokens_checked,
    output logic [18:0] kinds_seen
);
    import srctok_pkg::*;

    localparam logic [7:0] LENGTH_CAP = 8'd255;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_MINUS,
        SCAN_EQUAL
    } scan_t;

    // lexer state mirrored from the block
    scan_t        scan;
    logic [15:0]  next_pos;
    logic [15:0]  tok_begin;
    logic [7:0]   tok_len;
    logic [47:0]  word_head;

    // tokens of the byte being predicted, then the in-order store
    token_t       step_buf [0:1];
    int           step_n;
    token_t       expected_tokens [$];

    function automatic logic numeral(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic alpha(input logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] len);
        return (len >= LENGTH_CAP) ? LENGTH_CAP : len + 8'd1;
    endfunction

    // single-byte operators that close immediately; anything else is none
    function automatic token_kind_t operator_kind(input logic [7:0] b);
        token_kind_t k;
        k = KIND_NONE;
        if (b == CH_PLUS)   k = KIND_PLUS;
        if (b == CH_STAR)   k = KIND_STAR;
        if (b == CH_SLASH)  k = KIND_SLASH;
        if (b == CH_LPAREN) k = KIND_LPAREN;
        if (b == CH_RPAREN) k = KIND_RPAREN;
        if (b == CH_LBRACE) k = KIND_LBRACE;
        if (b == CH_RBRACE) k = KIND_RBRACE;
        if (b == CH_COLON)  k = KIND_COLON;
        if (b == CH_DOT)    k = KIND_DOT;
        return k;
    endfunction

    // keywords need the exact length and the leading bytes
    function automatic token_kind_t word_kind();
        token_kind_t k;
        k = KIND_IDENT;
        if (tok_len == 8'd3 && word_head == KW_LET)    k = KIND_LET;
        if (tok_len == 8'd5 && word_head == KW_CONST)  k = KIND_CONST;
        if (tok_len == 8'd2 && word_head == KW_FN)     k = KIND_FN;
        if (tok_len == 8'd6 && word_head == KW_RETURN) k = KIND_RETURN;
        return k;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_token(input token_kind_t k, input logic [15:0] s,
                               input logic [7:0] l);
        if (step_n < 2)
        begin
            step_buf[step_n].kind   = k;
            step_buf[step_n].start  = s;
            step_buf[step_n].length = l;
            step_buf[step_n].last   = 1'b0;
            step_n++;
        end
    endtask

    // emit whatever token is pending and go back to idle
    task automatic close_pending();
        case (scan)
            SCAN_NUMBER: queue_token(KIND_NUMBER, tok_begin, tok_len);
            SCAN_WORD:   queue_token(word_kind(), tok_begin, tok_len);
            SCAN_MINUS:  queue_token(KIND_MINUS, tok_begin, 8'd1);
            SCAN_EQUAL:  queue_token(KIND_EQUAL, tok_begin, 8'd1);
            default:     ;
        endcase
        scan = SCAN_IDLE;
    endtask

    // a byte seen with nothing pending
    task automatic open_token(input logic [7:0] b, input logic [15:0] p);
        token_kind_t k;
        scan = SCAN_IDLE;
        if (!blank(b))
        begin
            tok_begin = p;
            tok_len   = 8'd1;
            word_head = '0;
            if (numeral(b))
                scan = SCAN_NUMBER;
            else if (alpha(b))
            begin
                scan      = SCAN_WORD;
                word_head = {40'd0, b};
            end
            else if (b == CH_MINUS)
                scan = SCAN_MINUS;
            else if (b == CH_EQUAL)
                scan = SCAN_EQUAL;
            else
            begin
                k = operator_kind(b);
                queue_token(k, p, (k == KIND_NONE) ? 8'd0 : 8'd1);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eoc);
        logic [15:0] p;
        p      = next_pos;
        step_n = 0;
        case (scan)
            SCAN_NUMBER:
                if (numeral(b))
                    tok_len = bump(tok_len);
                else
                begin
                    close_pending();
                    open_token(b, p);
                end
            SCAN_WORD:
                if (numeral(b) || alpha(b))
                begin
                    if (tok_len < 8'd6)
                        word_head = {word_head[39:0], b};
                    tok_len = bump(tok_len);
                end
                else
                begin
                    close_pending();
                    open_token(b, p);
                end
            SCAN_MINUS:
                if (numeral(b))
                begin
                    scan    = SCAN_NUMBER;
                    tok_len = bump(8'd1);
                end
                else
                begin
                    close_pending();
                    open_token(b, p);
                end
            SCAN_EQUAL:
                if (b == CH_EQUAL)
                begin
                    queue_token(KIND_EQEQ, tok_begin, 8'd2);
                    scan = SCAN_IDLE;
                end
                else
                begin
                    close_pending();
                    open_token(b, p);
                end
            default:
                open_token(b, p);
        endcase

        // end of source flushes and restarts the position count
        if (eoc)
        begin
            close_pending();
            next_pos = '0;
        end
        else
            next_pos = p + 16'd1;

        if (step_n > 0)
            step_buf[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_tokens.insert(expected_tokens.size(), step_buf[i]);
    endtask

    // compare output words first, then predict the byte taken at this edge
    always @(posedge clk or negedge rst_n)
    begin : track
        token_t want;
        if (!rst_n)
        begin
            scan           = SCAN_IDLE;
            next_pos       = '0;
            tok_begin      = '0;
            tok_len        = '0;
            word_head      = '0;
            step_n         = 0;
            expected_tokens.delete();
            mismatches     = 0;
            tokens_due     = 0;
            tokens_checked = 0;
            kinds_seen     = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                    flag_error($sformatf("token with none expected: kind %0d start %0d len %0d",
                                         token_kind, token_start, token_length));
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                        flag_error($sformatf("token %0d kind %0d, expected %0d",
                                             tokens_checked, token_kind, want.kind));
                    if (token_start !== want.start)
                        flag_error($sformatf("token %0d start %0d, expected %0d",
                                             tokens_checked, token_start, want.start));
                    if (token_length !== want.length)
                        flag_error($sformatf("token %0d length %0d, expected %0d",
                                             tokens_checked, token_length, want.length));
                    if (last_of_run !== want.last)
                        flag_error($sformatf("token %0d last %0b, expected %0b",
                                             tokens_checked, last_of_run, want.last));
                end
                if (token_kind <= 5'd18)
                    kinds_seen[token_kind] = 1'b1;
                tokens_checked++;
            end
            if (in_valid && in_ready)
                predict_byte(code_byte, end_of_code);
            tokens_due = expected_tokens.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives source text into the tokenizer: a short directed source, very long
// tokens and randomized token streams with noise, with random gaps and
// stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import srctok_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AT_WORD = 120;
    localparam int TAIL_CYCLES  = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        end_of_code;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;

    int          mismatches;
    int          tokens_due;
    int          tokens_checked;
    logic [18:0] kinds_seen;

    bit          tx_burst;
    int          bytes_sent;
    int          sources_sent;
    int          idle_cycles;
    logic [7:0]  text_q [$];
    string       keywords [0:3] = '{"let", "const", "fn", "return"};
    string       operators = "+-*/(){}:=.";

    source_tokenizer #(
        .POSITION_BITS    (16),
        .MAX_TOKEN_LENGTH (255)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .end_of_code  (end_of_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    tokenizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_byte      (code_byte),
        .end_of_code    (end_of_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .token_start    (token_start),
        .token_length   (token_length),
        .last_of_run    (last_of_run),
        .mismatches     (mismatches),
        .tokens_due     (tokens_due),
        .tokens_checked (tokens_checked),
        .kinds_seen     (kinds_seen)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // 0..9 digits, 10..61 letters
    function automatic logic [7:0] pick_char(input int idx);
        if (idx < 10)
            return CH_0 + idx[7:0];
        else if (idx < 36)
            return CH_LA + idx[7:0] - 8'd10;
        else
            return CH_UA + idx[7:0] - 8'd36;
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_LF;
            3:       b = CH_VT;
            4:       b = CH_FF;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

    // one byte onto the end of the pending source text
    task automatic append_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    // offer one word and hold it until taken; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic eoc);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        code_byte   <= b;
        end_of_code <= eoc;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_source(input bit with_end);
        for (int i = 0; i < text_q.size(); i++)
            push_byte(text_q[i], with_end && (i == text_q.size() - 1));
        if (with_end)
            sources_sent++;
        text_q.delete();
    endtask

    // no progress on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side: random stalls, ready bursts, one long hold to back up the block
    initial
    begin : drain_side
        int stall;
        int burst_left;
        int words_taken;
        bit held;
        burst_left  = 0;
        words_taken = 0;
        held        = 1'b0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && words_taken == HOLD_AT_WORD)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (burst_left > 0)
            begin
                stall = 0;
                burst_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall      = 0;
                burst_left = $urandom_range(10, 40);
            end
            else
                stall = $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            words_taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int         random_items;
        int         n_tok;
        int         sel;
        int         len;
        int         kinds_hit;
        string      kw;
        logic [7:0] b;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        code_byte    = 8'h00;
        end_of_code  = 1'b0;
        tx_burst     = 1'b0;
        bytes_sent   = 0;
        sources_sent = 0;
        random_items = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every operator, minus joining a number, equal then unknown,
        // byte extremes, whitespace, a pending minus flushed by end of source
        add_text("(a+-3)*{b:c}/d.e==f=");
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(CH_TAB);
        append_byte(CH_MINUS);
        send_source(1'b1);
        // one-byte source
        add_text("7");
        send_source(1'b1);

        // saturating lengths: a keyword-led identifier and a negative number
        add_text("return");
        repeat (300) append_byte(pick_char($urandom_range(0, 61)));
        append_byte(CH_SPACE);
        append_byte(CH_MINUS);
        repeat (270) append_byte(pick_char($urandom_range(0, 9)));
        send_source(1'b1);

        // random token streams, some noise, some without an end mark
        while (random_items < RANDOM_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 12);
                repeat (len) append_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                n_tok = $urandom_range(1, 12);
                repeat (n_tok)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel <= 3)
                        add_text(keywords[$urandom_range(0, 3)]);
                    else if (sel <= 5)
                    begin
                        // near misses of keywords
                        kw = keywords[$urandom_range(0, 3)];
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                add_text(kw);
                                append_byte(pick_char($urandom_range(0, 61)));
                            end
                            1: add_text(kw.substr(0, kw.len() - 2));
                            default:
                            begin
                                append_byte(kw[0] - 8'd32);
                                add_text(kw.substr(1, kw.len() - 1));
                            end
                        endcase
                    end
                    else if (sel <= 8)
                    begin
                        append_byte(pick_char($urandom_range(10, 61)));
                        repeat ($urandom_range(0, 7))
                            append_byte(pick_char($urandom_range(0, 61)));
                    end
                    else if (sel <= 11)
                    begin
                        if (sel == 11)
                            append_byte(CH_MINUS);
                        repeat ($urandom_range(1, 6))
                            append_byte(pick_char($urandom_range(0, 9)));
                    end
                    else if (sel <= 15)
                        append_byte(operators[$urandom_range(0, 10)]);
                    else if (sel == 16)
                        add_text("==");
                    else if (sel == 17)
                    begin
                        // a byte outside every class
                        case ($urandom_range(0, 3))
                            0:       b = 8'($urandom_range(8'h80, 8'hFF));
                            1:       b = 8'($urandom_range(8'h00, 8'h08));
                            2:       b = 8'($urandom_range(8'h0E, 8'h1F));
                            default:
                            begin
                                kw = "!\"#$%&',;<>?@[\\]^_|~";
                                b  = kw[$urandom_range(0, kw.len() - 1)];
                            end
                        endcase
                        append_byte(b);
                    end
                    else
                        append_byte(8'($urandom_range(0, 255)));
                    // separator: none, one or two whitespace bytes
                    sel = $urandom_range(0, 5);
                    if (sel >= 2)
                        append_byte(pick_blank());
                    if (sel == 5)
                        append_byte(pick_blank());
                end
            end
            random_items += text_q.size();
            send_source($urandom_range(0, 4) != 0);
        end

        // close any open source, then one last mixed source
        tx_burst = 1'b0;
        add_text(" ");
        send_source(1'b1);
        add_text("abcde+-4 7:=");
        send_source(1'b1);
        in_valid    <= 1'b0;
        end_of_code <= 1'b0;

        do @(negedge clk); while (tokens_due != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        kinds_hit = 0;
        for (int i = 0; i < 19; i++)
            kinds_hit += kinds_seen[i];
        $display("Sent %0d bytes in %0d terminated sources; %0d tokens checked",
                 bytes_sent, sources_sent, tokens_checked);
        $display("Saw %0d of 19 token kinds, including saturated lengths",
                 kinds_hit);
        if (mismatches == 0 && tokens_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/srctok_pkg.sv
rtl/core/srctok_lexer.sv
rtl/core/srctok_queue.sv
rtl/core/source_tokenizer.sv
tb/tokenizer_checker.sv
tb/tb_top.sv
